// ===== hdl/ascii_to_signed_integer_core_macros.svh =====
// Assertion macros shared by the string-to-integer parser RTL.
`ifndef ASCII_TO_SIGNED_INTEGER_CORE_MACROS_SVH
`define ASCII_TO_SIGNED_INTEGER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define A2SI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("a2si assertion failed");
`define A2SI_ASSERT_NEVER(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
    else $error("a2si forbidden condition seen");
`else
`define A2SI_ASSERT(lbl, clk, rst, prop)
`define A2SI_ASSERT_NEVER(lbl, clk, rst, prop)
`endif

`endif

// ===== hdl/a2si_pkg.sv =====
// Shared types and constants for the string-to-integer parser.
`default_nettype none
package a2si_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;
  localparam int BASE_W         = 6;
  localparam int CHAR_W         = 8;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              string_start;
  } item_t;

endpackage
`default_nettype wire

// ===== hdl/a2si_in_stage.sv =====
// Input register stage: holds one item until the parser takes it.
`default_nettype none
module a2si_in_stage
  import a2si_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  input  wire logic  take,
  output logic       stall,
  output logic       item_valid,
  output item_t      item
);

  logic load;

  assign stall = item_valid && !take;
  assign load  = in_valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/a2si_parser.sv =====
// Parser state and per-character step logic: whitespace, sign, prefix, digits.
`default_nettype none
`include "ascii_to_signed_integer_core_macros.svh"
module a2si_parser
  import a2si_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  input  wire item_t                 item,
  input  wire logic [BASE_W-1:0]     number_base,
  input  wire logic                  out_free,
  output logic                       fire,
  output logic                       res_emit,
  output logic [VALUE_BITS-1:0]      res_value,
  output logic                       res_range_error,
  output logic [COUNT_BITS-1:0]      res_count
);

  localparam int PW = VALUE_BITS + BASE_W;
  localparam logic [VALUE_BITS-1:0] HALF    = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] HALF_M1 = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [BASE_W-1:0]     NO_DIGIT = '1;
  localparam logic [BASE_W-1:0]     B_OCT = 6'd8;
  localparam logic [BASE_W-1:0]     B_DEC = 6'd10;
  localparam logic [BASE_W-1:0]     B_HEX = 6'd16;
  localparam logic [BASE_W-1:0]     B_MIN = 6'd2;
  localparam logic [BASE_W-1:0]     B_MAX = 6'd36;
  localparam logic [BASE_W-1:0]     B_AUTO = 6'd0;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] OFS_UA   = 8'd55;
  localparam logic [CHAR_W-1:0] OFS_LA   = 8'd87;

  typedef enum logic [2:0] {
    PH_SKIP_WS,
    PH_SIGNED,
    PH_ZERO,
    PH_X,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] t;
    begin
      t = '0;
      if (c >= CH_0 && c <= CH_9) begin
        t = c - CH_0;
      end else if (c >= CH_LA && c <= CH_LZ) begin
        t = c - OFS_LA;
      end else if (c >= CH_UA && c <= CH_UZ) begin
        t = c - OFS_UA;
      end else begin
        t = CHAR_W'(NO_DIGIT);
      end
      digit_of = t[BASE_W-1:0];
    end
  endfunction

  phase_t                  phase, phase_next, cur_phase;
  logic                    neg, neg_next, cur_neg;
  logic                    ovf, ovf_next, cur_ovf;
  logic                    dig, dig_next, cur_dig;
  logic [VALUE_BITS-1:0]   acc, acc_next, cur_acc;
  logic [BASE_W-1:0]       abase, abase_next, cur_abase;
  logic [COUNT_BITS-1:0]   pos, pos_next, cur_pos;

  logic [BASE_W-1:0]       dval;
  logic [BASE_W-1:0]       sel_base;
  logic                    is_ws;
  logic                    start_num;
  logic                    digit_path;
  logic                    do_acc;
  logic                    x_fail;
  logic                    emit;
  logic                    over;
  logic [PW-1:0]           prod;
  logic [PW-1:0]           limit;
  logic [VALUE_BITS-1:0]   emit_acc;
  logic [COUNT_BITS-1:0]   emit_cnt;

  // string start clears the parse before the character is used
  assign cur_phase = item.string_start ? PH_SKIP_WS : phase;
  assign cur_neg   = item.string_start ? 1'b0 : neg;
  assign cur_ovf   = item.string_start ? 1'b0 : ovf;
  assign cur_dig   = item.string_start ? 1'b0 : dig;
  assign cur_acc   = item.string_start ? '0 : acc;
  assign cur_abase = item.string_start ? '0 : abase;
  assign cur_pos   = item.string_start ? '0 : pos;

  assign dval  = digit_of(item.character);
  assign is_ws = (item.character == CH_SPACE) ||
                 (item.character >= CH_TAB && item.character <= CH_CR);

  assign limit = cur_neg ? PW'(HALF) : PW'(HALF_M1);

  always_comb begin
    phase_next = cur_phase;
    neg_next   = cur_neg;
    abase_next = cur_abase;
    sel_base   = cur_abase;
    start_num  = 1'b0;
    digit_path = 1'b0;
    do_acc     = 1'b0;
    x_fail     = 1'b0;
    dig_next   = cur_dig;
    acc_next   = cur_acc;
    ovf_next   = cur_ovf;

    unique case (cur_phase)
      PH_SKIP_WS: begin
        if (is_ws) begin
          phase_next = PH_SKIP_WS;
        end else if (item.character == CH_MINUS) begin
          neg_next   = 1'b1;
          phase_next = PH_SIGNED;
        end else if (item.character == CH_PLUS) begin
          phase_next = PH_SIGNED;
        end else begin
          start_num = 1'b1;
        end
      end
      PH_SIGNED: begin
        start_num = 1'b1;
      end
      PH_ZERO: begin
        if (item.character == CH_LX || item.character == CH_UX) begin
          phase_next = PH_X;
        end else begin
          sel_base   = (cur_abase == B_AUTO) ? B_OCT : cur_abase;
          abase_next = sel_base;
          digit_path = 1'b1;
        end
      end
      PH_X: begin
        if (dval < B_HEX) begin
          sel_base   = B_HEX;
          abase_next = B_HEX;
          do_acc     = 1'b1;
        end else begin
          x_fail = 1'b1;
        end
      end
      PH_DIGITS: begin
        digit_path = 1'b1;
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    if (start_num) begin
      if ((number_base == B_AUTO || number_base == B_HEX) && item.character == CH_0) begin
        abase_next = number_base;
        acc_next   = '0;
        dig_next   = 1'b1;
        phase_next = PH_ZERO;
      end else begin
        sel_base   = (number_base == B_AUTO) ? B_DEC : number_base;
        abase_next = sel_base;
        digit_path = 1'b1;
      end
    end

    // one multiply-add and compare per character
    prod = PW'(cur_acc) * PW'(sel_base) + PW'(dval);
    over = cur_ovf || (prod > limit);

    emit = x_fail;
    if (digit_path) begin
      if (sel_base < B_MIN || sel_base > B_MAX || dval >= sel_base) begin
        emit = 1'b1;
      end else begin
        do_acc = 1'b1;
      end
    end

    if (do_acc) begin
      ovf_next   = over;
      if (!over) begin
        acc_next = prod[VALUE_BITS-1:0];
      end
      dig_next   = 1'b1;
      phase_next = PH_DIGITS;
    end

    if (emit) begin
      phase_next = PH_DONE;
    end
  end

  assign pos_next = (cur_pos == CNT_MAX) ? cur_pos : cur_pos + COUNT_BITS'(1);

  assign emit_acc = x_fail ? '0 : cur_acc;

  always_comb begin
    if (!cur_dig) begin
      emit_cnt = '0;
    end else if (x_fail && cur_pos != CNT_MAX) begin
      emit_cnt = cur_pos - COUNT_BITS'(1);
    end else begin
      emit_cnt = cur_pos;
    end
  end

  always_comb begin
    if (!cur_dig) begin
      res_value = '0;
    end else if (cur_ovf) begin
      res_value = cur_neg ? HALF : HALF_M1;
    end else begin
      res_value = cur_neg ? ('0 - emit_acc) : emit_acc;
    end
  end

  assign res_range_error = cur_ovf;
  assign res_count       = emit_cnt;
  assign res_emit        = item_valid && emit;
  assign fire            = item_valid && (!emit || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SKIP_WS;
      neg   <= 1'b0;
      ovf   <= 1'b0;
      dig   <= 1'b0;
      acc   <= '0;
      abase <= '0;
      pos   <= '0;
    end else if (fire) begin
      phase <= phase_next;
      neg   <= neg_next;
      ovf   <= ovf_next;
      dig   <= dig_next;
      acc   <= acc_next;
      abase <= abase_next;
      pos   <= pos_next;
    end
  end

  `A2SI_ASSERT(a_emit_done, clk, rst, (fire && res_emit) |=> (phase == PH_DONE))
  `A2SI_ASSERT(a_ovf_limit, clk, rst, (res_emit && res_range_error) |-> (res_value == HALF || res_value == HALF_M1))
  `A2SI_ASSERT_NEVER(a_zero_count, clk, rst, res_emit && (res_count == '0) && (res_value != '0))

endmodule
`default_nettype wire

// ===== hdl/a2si_out_stage.sv =====
// Result register: holds one result item until the receiver takes it.
`default_nettype none
module a2si_out_stage
  import a2si_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic [VALUE_BITS-1:0] load_value,
  input  wire logic                  load_range_error,
  input  wire logic [COUNT_BITS-1:0] load_count,
  input  wire logic                  out_stall,
  output logic                       out_free,
  output logic                       out_valid,
  output logic signed [VALUE_BITS-1:0] value,
  output logic                       range_error,
  output logic [COUNT_BITS-1:0]      consumed_count
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value          <= load_value;
      range_error    <= load_range_error;
      consumed_count <= load_count;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ascii_to_signed_integer_core.sv =====
// Top level of the character-serial string-to-integer parser.
//
// Characters enter on the input channel (in_valid/in_stall, character, string_start),
// one per item; string_start marks the first character of a new string.
// A result (value, range_error, consumed_count) leaves on the output channel
// (out_valid/out_stall) when the parser meets the first character it cannot use,
// NUL included; further characters give no result until the next string start.
// The user must write number_base through cfg_write_en/cfg_write_data only while
// idle; the block itself does not enforce this. Throughput: one item per cycle while
// no result meets a full, stalled result register, set by the parser state update, a
// single multiply-add and limit compare per character. A character is held in the
// input register, and its result is then registered in the result register.
// A stalled result holds in the result register; the input side keeps taking
// items until one that would give a result finds the register still full.
// Reset: synchronous, clears both stages, the parse state, and sets the base to 10.
`default_nettype none
`include "ascii_to_signed_integer_core_macros.svh"
module ascii_to_signed_integer_core
  import a2si_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write_en,
  input  wire logic [BASE_W-1:0]       cfg_write_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [CHAR_W-1:0]       character,
  input  wire logic                    string_start,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [VALUE_BITS-1:0] value,
  output logic                         range_error,
  output logic [COUNT_BITS-1:0]        consumed_count
);

  logic [BASE_W-1:0]     number_base;
  item_t                 in_item;
  item_t                 item;
  logic                  item_valid;
  logic                  fire;
  logic                  out_free;
  logic                  res_emit;
  logic [VALUE_BITS-1:0] res_value;
  logic                  res_range_error;
  logic [COUNT_BITS-1:0] res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_RESET;
    end else if (cfg_write_en) begin
      number_base <= cfg_write_data;
    end
  end

  assign in_item.character    = character;
  assign in_item.string_start = string_start;

  a2si_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .take       (fire),
    .stall      (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  a2si_parser #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item            (item),
    .number_base     (number_base),
    .out_free        (out_free),
    .fire            (fire),
    .res_emit        (res_emit),
    .res_value       (res_value),
    .res_range_error (res_range_error),
    .res_count       (res_count)
  );

  a2si_out_stage #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_out (
    .clk              (clk),
    .rst              (rst),
    .load             (fire && res_emit),
    .load_value       (res_value),
    .load_range_error (res_range_error),
    .load_count       (res_count),
    .out_stall        (out_stall),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .value            (value),
    .range_error      (range_error),
    .consumed_count   (consumed_count)
  );

  `A2SI_ASSERT(a_stall_cause, clk, rst, in_stall |-> (out_valid && out_stall))

endmodule
`default_nettype wire

// ===== tb/tb_ascii_to_signed_integer_core.sv =====
// Self-checking testbench for the character-serial string-to-integer parser.
`timescale 1ns / 100ps
module tb_ascii_to_signed_integer_core;
  import a2si_pkg::*;

  typedef enum logic [2:0] {
    PH_SKIP_WS, PH_SIGN, PH_LEAD_ZERO, PH_HEX_X, PH_DIGITS, PH_DONE
  } parse_phase_t;

  typedef struct {
    logic signed [31:0] value;
    logic               range_error;
    logic [15:0]        consumed_count;
  } parse_result_t;

  localparam logic [6:0]  NOT_A_DIGIT = 7'd99;
  localparam logic [31:0] POS_LIMIT   = 32'h7fff_ffff;
  localparam logic [31:0] NEG_LIMIT   = 32'h8000_0000;
  localparam logic [15:0] COUNT_MAX   = 16'hffff;
  localparam logic [7:0]  NUL         = 8'h00;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [BASE_W-1:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CHAR_W-1:0] character = '0;
  logic string_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] value;
  logic range_error;
  logic [15:0] consumed_count;

  ascii_to_signed_integer_core DUT (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .character(character), .string_start(string_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .range_error(range_error), .consumed_count(consumed_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  item_t pending_chars[$];
  parse_result_t expected_numbers[$];
  bit open_string = 1'b0;
  int items_queued = 0;
  int results_checked = 0;
  int bases_used = 0;
  int errors = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int gap_left = 0;
  int stall_left = 0;

  // parser state as predicted
  parse_phase_t ph = PH_SKIP_WS;
  logic neg = 1'b0;
  logic [31:0] acc = '0;
  logic ovf = 1'b0;
  logic seen = 1'b0;
  logic [5:0] act_base = '0;
  logic [15:0] pos = '0;
  logic [5:0] cur_base = BASE_RESET;

  function automatic logic [6:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 7'(c - "0");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 10);
    if (c >= "A" && c <= "Z") return 7'(c - "A" + 10);
    return NOT_A_DIGIT;
  endfunction

  function automatic void clear_number();
    ph = PH_SKIP_WS;
    neg = 1'b0;
    acc = '0;
    ovf = 1'b0;
    seen = 1'b0;
    act_base = '0;
    pos = '0;
  endfunction

  function automatic void add_digit(input logic [6:0] d);
    logic [31:0] limit, cutoff, cutlim;
    limit = neg ? NEG_LIMIT : POS_LIMIT;
    cutoff = limit / act_base;
    cutlim = limit % act_base;
    if (ovf || acc > cutoff || (acc == cutoff && d > cutlim))
      ovf = 1'b1;
    else
      acc = acc * act_base + d;
    seen = 1'b1;
    ph = PH_DIGITS;
  endfunction

  function automatic void emit_number(input logic [15:0] cnt);
    parse_result_t r;
    if (!seen) r.value = '0;
    else if (ovf) r.value = neg ? NEG_LIMIT : POS_LIMIT;
    else r.value = neg ? -acc : acc;
    r.range_error = ovf;
    r.consumed_count = seen ? cnt : '0;
    expected_numbers.push_back(r);
    ph = PH_DONE;
  endfunction

  function automatic void digit_path(input logic [7:0] c);
    logic [6:0] d;
    d = digit_value(c);
    if (act_base < 2 || act_base > 36 || d >= act_base) emit_number(pos);
    else add_digit(d);
  endfunction

  function automatic void start_number(input logic [7:0] c);
    act_base = cur_base;
    if ((cur_base == 0 || cur_base == 16) && c == "0") begin
      acc = '0;
      seen = 1'b1;
      ph = PH_LEAD_ZERO;
    end else begin
      if (cur_base == 0) act_base = 6'd10;
      digit_path(c);
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic s);
    if (s) clear_number();
    case (ph)
      PH_SKIP_WS: begin
        if (c == "-") begin
          neg = 1'b1;
          ph = PH_SIGN;
        end else if (c == "+") begin
          ph = PH_SIGN;
        end else if (c != " " && (c < 8'd9 || c > 8'd13)) begin
          start_number(c);
        end
      end
      PH_SIGN: start_number(c);
      PH_LEAD_ZERO: begin
        if (c == "x" || c == "X") begin
          ph = PH_HEX_X;
        end else begin
          if (act_base == 0) act_base = 6'd8;
          digit_path(c);
        end
      end
      PH_HEX_X: begin
        if (digit_value(c) < 16) begin
          act_base = 6'd16;
          add_digit(digit_value(c));
        end else begin
          // "0x" with no hex digit: number is the lone zero
          acc = '0;
          emit_number(pos == COUNT_MAX ? COUNT_MAX : pos - 16'd1);
        end
      end
      PH_DIGITS: digit_path(c);
      default: ;
    endcase
    if (pos != COUNT_MAX) pos++;
  endfunction

  // driver
  always @(posedge clk) begin : drive
    item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
        in_valid <= 1'b0;
        gap_left = $urandom_range(2, 0);
      end else if (pending_chars.size() != 0) begin
        it = pending_chars.pop_front();
        in_valid <= 1'b1;
        character <= it.character;
        string_start <= it.string_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(2, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    parse_result_t e;
    if (!rst) begin
      if (in_valid && !in_stall) parse_char(character, string_start);
      if (out_valid && !out_stall) begin
        if (expected_numbers.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual value %0d count %0d",
                   $time, value, consumed_count);
        end else begin
          e = expected_numbers.pop_front();
          results_checked++;
          if (value !== e.value) begin
            errors++;
            $display("%0t: value expected %0d actual %0d", $time, e.value, value);
          end
          if (range_error !== e.range_error) begin
            errors++;
            $display("%0t: range_error expected %0b actual %0b",
                     $time, e.range_error, range_error);
          end
          if (consumed_count !== e.consumed_count) begin
            errors++;
            $display("%0t: consumed_count expected %0d actual %0d",
                     $time, e.consumed_count, consumed_count);
          end
        end
      end
    end
  end

  task automatic put(input logic [7:0] c, input bit counted = 1'b1);
    pending_chars.push_back('{character: c, string_start: open_string});
    open_string = 1'b0;
    if (counted) items_queued++;
  endtask

  task automatic put_text(input string s);
    open_string = 1'b1;
    foreach (s[i]) put(s[i]);
  endtask

  task automatic drain();
    while (pending_chars.size() != 0 || in_valid || expected_numbers.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_base(input logic [5:0] b);
    drain();
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= b;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_base = b;
    bases_used++;
  endtask

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(1, 0) ? "a" : "A") + d - 10);
  endfunction

  // mostly well-formed numbers with random content, some noise
  task automatic queue_random_string();
    logic [63:0] mag;
    logic [7:0] digs[$];
    int eb, pick;
    bit prefixed;
    open_string = 1'b1;
    if ($urandom_range(99, 0) < 12) begin
      repeat ($urandom_range(6, 1)) put(8'($urandom_range(255, 0)));
      return;
    end
    repeat ($urandom_range(3, 0)) begin
      pick = $urandom_range(5, 0);
      put(pick == 5 ? " " : 8'(9 + pick));
    end
    pick = $urandom_range(2, 0);
    if (pick == 0) put("-");
    else if (pick == 1) put("+");
    eb = (cur_base >= 2 && cur_base <= 36) ? cur_base : 10;
    prefixed = ((cur_base == 0 || cur_base == 16) && $urandom_range(2, 0) == 0) ||
               $urandom_range(19, 0) == 0;
    if (prefixed) begin
      put("0");
      put($urandom_range(1, 0) ? "x" : "X");
      if (cur_base == 0) eb = 16;
    end else if (cur_base == 0 && $urandom_range(2, 0) == 0) begin
      put("0");
      eb = 8;
    end
    if (!(prefixed && $urandom_range(4, 0) == 0)) begin
      case ($urandom_range(9, 0))
        0: mag = 64'h7fff_fffe + $urandom_range(3, 0);
        1: mag = {$urandom, $urandom};
        2: mag = '0;
        3, 4, 5: mag = $urandom_range(999, 0);
        default: mag = $urandom;
      endcase
      do begin
        digs.push_front(digit_char(int'(mag % eb)));
        mag = mag / eb;
      end while (mag != 0);
      foreach (digs[i]) put(digs[i]);
    end
    pick = $urandom_range(9, 0);
    if (pick <= 4) begin
      put(NUL);
    end else if (pick <= 7) begin
      put(8'($urandom_range(255, 0)));
    end else if (pick == 9) begin
      put(NUL);
      repeat ($urandom_range(3, 1)) put(8'($urandom_range(255, 0)), 1'b0);
    end
  endtask

  int phase_bases[11] = '{16, 2, 36, 0, 8, 63, 1, 10, 0, 37, 10};

  initial begin
    int mark;
    phase_bases[8] = $urandom_range(35, 3);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // first item after reset carries no string start
    open_string = 1'b0;
    put("7");
    put(NUL);
    put_text("\v+5x");
    put_text("12");
    put_text("-3");
    put(NUL);
    put("4");
    open_string = 1'b1;
    put(8'hff);
    set_base(6'd0);
    @(negedge clk);
    put_text("0x1F");
    put(NUL);
    put_text("09");
    put_text("0xg");
    set_base(6'd36);
    @(negedge clk);
    put_text("-zzzzzz");
    put(NUL);
    put_text("zzzzzz");
    put(NUL);
    set_base(6'd1);
    @(negedge clk);
    put_text("5");
    for (int p = 0; p < 11; p++) begin
      set_base(6'(phase_bases[p]));
      @(negedge clk);
      case ($urandom_range(2, 0))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 35;
      endcase
      stall_pct = $urandom_range(2, 0) * 15;
      if (p == 10) begin
        gap_pct = 0;
        stall_pct = 0;
      end
      mark = items_queued;
      while (items_queued - mark < 150) queue_random_string();
      open_string = 1'b1;
      put(NUL);
    end
    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d characters under %0d radix settings", items_queued, bases_used);
    $display("checked %0d parsed numbers, %0d mismatches", results_checked, errors);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

endmodule
